// File: sv/shc3_pkg.sv
// shared types and constants of the 3x3 sharpen filter
// no dependencies
package shc3_pkg;

    localparam int MAX_WIDTH = 2048;

    typedef logic [23:0] pixel_t;

    // window indexed [column][row], column 0 left, row 0 top
    typedef pixel_t [2:0][2:0] window_t;

    typedef struct packed {
        logic [10:0] col_prev;
        logic [10:0] col_last;
        logic [15:0] row;
        logic [15:0] row_prev;
        logic        above;
        logic        has_prev;
        logic        last_col;
        logic        last_row;
        logic        conv_ok;
    } item_t;

    typedef struct packed {
        logic [10:0] col;
        logic [15:0] row;
        pixel_t      pix;
        logic        eof;
    } result_t;

    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_KERNEL_TOP    = 3'd2;
    localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd3;
    localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd4;

    localparam logic [11:0] RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [15:0] RST_IMAGE_HEIGHT  = 16'd480;
    localparam logic [23:0] RST_KERNEL_TOP    = 24'h00FF00;
    localparam logic [23:0] RST_KERNEL_MIDDLE = 24'hFF05FF;
    localparam logic [23:0] RST_KERNEL_BOTTOM = 24'h00FF00;

    localparam logic [7:0] CHAN_MAX = 8'd255;

endpackage

// File: sv/shc3_linebuf.sv
// two-line buffer memory with read-modify-write and the 3x3 pixel window
// depends on shc3_pkg
module shc3_linebuf #(
    parameter int MAX_WIDTH = 2048,
    parameter int AW        = 11
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  shc3_pkg::pixel_t wr_pix,
    output shc3_pkg::window_t win
);
    import shc3_pkg::*;

    // entry holds {older line, newer line}
    logic [47:0] mem [MAX_WIDTH];
    logic [47:0] rd_reg;
    window_t     win_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= {rd_reg[23:0], wr_pix};
            win_reg[0]    <= win_reg[1];
            win_reg[1]    <= win_reg[2];
            win_reg[2][0] <= rd_reg[47:24];
            win_reg[2][1] <= rd_reg[23:0];
            win_reg[2][2] <= wr_pix;
        end
    end

    assign win = win_reg;

endmodule

// File: sv/shc3_mac.sv
// per-channel 3x3 multiply stage and clamped sum
// depends on shc3_pkg
module shc3_mac (
    input  logic              aclk,
    input  logic              en,
    input  logic [2:0][23:0]  kern,
    input  shc3_pkg::window_t win,
    output shc3_pkg::pixel_t  conv
);
    import shc3_pkg::*;

    logic signed [16:0] prod_reg [3][3][3];
    logic signed [20:0] acc [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int r = 0; r < 3; r++) begin
                    for (int k = 0; k < 3; k++) begin
                        prod_reg[ch][r][k] <= $signed({1'b0, win[k][r][16-8*ch +: 8]})
                                              * $signed(kern[r][8*k +: 8]);
                    end
                end
            end
        end
    end

    always_comb begin
        conv = '0;
        for (int ch = 0; ch < 3; ch++) begin
            acc[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    acc[ch] = acc[ch] + 21'(prod_reg[ch][r][k]);
                end
            end
            if (acc[ch] < 0) begin
                conv[16-8*ch +: 8] = '0;
            end else if (acc[ch] > 21'sd255) begin
                conv[16-8*ch +: 8] = CHAN_MAX;
            end else begin
                conv[16-8*ch +: 8] = acc[ch][7:0];
            end
        end
    end

endmodule

// File: sv/shc3_emit.sv
// result sequencer: holds up to four results of one item, sends one per cycle while out_ready is high
// depends on shc3_pkg
module shc3_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  shc3_pkg::item_t   item,
    input  shc3_pkg::pixel_t  conv,
    input  shc3_pkg::pixel_t  newer_center,
    input  shc3_pkg::pixel_t  newer_right,
    input  shc3_pkg::pixel_t  cur_center,
    input  shc3_pkg::pixel_t  cur_right,
    output logic              ready,
    output logic              out_valid,
    input  logic              out_ready,
    output shc3_pkg::result_t out_res,
    output logic              out_last
);
    import shc3_pkg::*;

    logic [3:0] mask_reg, mask_next, rest;
    result_t    rec_reg [4];
    logic       fire;

    assign rest      = mask_reg & (mask_reg - 4'd1);
    assign out_valid = (mask_reg != '0);
    assign out_last  = (rest == '0);
    assign fire      = out_valid && out_ready;
    assign ready     = !out_valid || (out_last && out_ready);

    always_comb begin
        out_res = rec_reg[3];
        if (mask_reg[0]) begin
            out_res = rec_reg[0];
        end else if (mask_reg[1]) begin
            out_res = rec_reg[1];
        end else if (mask_reg[2]) begin
            out_res = rec_reg[2];
        end
    end

    always_comb begin
        mask_next = mask_reg;
        if (fire) begin
            mask_next = rest;
        end
        if (load) begin
            mask_next = {item.last_row && item.last_col, item.last_row && item.has_prev,
                         item.above && item.last_col, item.above && item.has_prev};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg[0] <= '{item.col_prev, item.row_prev,
                            item.conv_ok ? conv : newer_center, 1'b0};
            rec_reg[1] <= '{item.col_last, item.row_prev, newer_right, 1'b0};
            rec_reg[2] <= '{item.col_prev, item.row, cur_center, 1'b0};
            rec_reg[3] <= '{item.col_last, item.row, cur_right, 1'b1};
        end
    end

endmodule

// File: sv/sharpen_3x3_convolution_top.sv
// 3x3 sharpen filter on a raster RGB stream: an accepted item passes item1_reg,
// item2_reg, item3_reg and the output sequencer before its first result (results
// trail the input image by one row and one column); throughput one item per cycle
// while the output is not stalled; an item with several results holds the input until
// the one-result-per-cycle output sequencer has sent them all; synchronous active-low
// reset clears counters, pipeline and output; line memory needs no clearing pass
module sharpen_3x3_convolution_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_red, out_green, out_blue, out_row, out_col
    output logic        m_tlast,
    output logic        m_tuser,   // end_of_frame
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import shc3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0][23:0] kern_reg;

    logic [AW-1:0] col_reg, col_next, xc, wlast;
    logic [15:0]   row_reg, row_next, yc, heff, hlast;
    logic [31:0]   weff;
    logic          accept, en, cfg_wr;

    logic          v1_reg, v2_reg, v3_reg;
    logic [AW-1:0] x1_reg;
    pixel_t        pix1_reg;
    item_t         item0, item1_reg, item2_reg, item3_reg;
    pixel_t        nc3_reg, nr3_reg, cc3_reg, cr3_reg;
    window_t       win;
    pixel_t        conv;
    result_t       res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= RST_IMAGE_WIDTH;
            height_reg  <= RST_IMAGE_HEIGHT;
            kern_reg[0] <= RST_KERNEL_TOP;
            kern_reg[1] <= RST_KERNEL_MIDDLE;
            kern_reg[2] <= RST_KERNEL_BOTTOM;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_IMAGE_WIDTH:   width_reg   <= pwdata[11:0];
                REG_IMAGE_HEIGHT:  height_reg  <= pwdata[15:0];
                REG_KERNEL_TOP:    kern_reg[0] <= pwdata[23:0];
                REG_KERNEL_MIDDLE: kern_reg[1] <= pwdata[23:0];
                REG_KERNEL_BOTTOM: kern_reg[2] <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_IMAGE_WIDTH:   prdata = {20'd0, width_reg};
            REG_IMAGE_HEIGHT:  prdata = {16'd0, height_reg};
            REG_KERNEL_TOP:    prdata = {8'd0, kern_reg[0]};
            REG_KERNEL_MIDDLE: prdata = {8'd0, kern_reg[1]};
            REG_KERNEL_BOTTOM: prdata = {8'd0, kern_reg[2]};
            default:           prdata = '0;
        endcase
    end

    // effective geometry and current position
    always_comb begin
        if (width_reg < 12'd3) begin
            weff = 32'd3;
        end else if (32'(width_reg) > MAX_WIDTH) begin
            weff = 32'(MAX_WIDTH);
        end else begin
            weff = 32'(width_reg);
        end
        wlast = AW'(weff - 32'd1);
        heff  = (height_reg < 16'd3) ? 16'd3 : height_reg;
        hlast = heff - 16'd1;
        xc    = (32'(col_reg) >= weff) ? '0 : col_reg;
        yc    = (row_reg >= heff) ? '0 : row_reg;
        if (xc == wlast) begin
            col_next = '0;
            row_next = (yc == hlast) ? '0 : yc + 16'd1;
        end else begin
            col_next = xc + AW'(1);
            row_next = yc;
        end
        item0.col_prev = 11'(32'(xc) - 32'd1);
        item0.col_last = 11'(32'(wlast));
        item0.row      = yc;
        item0.row_prev = yc - 16'd1;
        item0.above    = (yc != '0);
        item0.has_prev = (xc != '0);
        item0.last_col = (xc == wlast);
        item0.last_row = (yc == hlast);
        item0.conv_ok  = (yc != 16'd1) && (xc != AW'(1));
    end

    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (en) begin
                v1_reg <= accept;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg    <= xc;
            pix1_reg  <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
            item1_reg <= item0;
            item2_reg <= item1_reg;
            item3_reg <= item2_reg;
            nc3_reg   <= win[1][1];
            nr3_reg   <= win[2][1];
            cc3_reg   <= win[1][2];
            cr3_reg   <= win[2][2];
        end
    end

    shc3_linebuf #(
        .MAX_WIDTH(MAX_WIDTH),
        .AW       (AW)
    ) u_linebuf (
        .aclk   (aclk),
        .rd_en  (accept),
        .rd_addr(xc),
        .wr_en  (v1_reg && en),
        .wr_addr(x1_reg),
        .wr_pix (pix1_reg),
        .win    (win)
    );

    shc3_mac u_mac (
        .aclk(aclk),
        .en  (en),
        .kern(kern_reg),
        .win (win),
        .conv(conv)
    );

    shc3_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (v3_reg && en),
        .item        (item3_reg),
        .conv        (conv),
        .newer_center(nc3_reg),
        .newer_right (nr3_reg),
        .cur_center  (cc3_reg),
        .cur_right   (cr3_reg),
        .ready       (en),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (res),
        .out_last    (m_tlast)
    );

    assign m_tdata = {5'd0, res.pix[7:0], res.pix[15:8], res.pix[23:16], res.row, res.col};
    assign m_tuser = res.eof;

    a_no_same_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && v1_reg |-> xc != x1_reg)
        else $error("line memory read and write hit the same entry");

    a_eof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of frame not on last result of its item");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !v1_reg)
        else $error("pipeline not empty after reset");

endmodule
